// File: hw/rtl/label_bbox_coverage_counter_macros.svh
// assertion helpers for the label coverage counter
`ifndef LABEL_BBOX_COVERAGE_COUNTER_MACROS_SVH
`define LABEL_BBOX_COVERAGE_COUNTER_MACROS_SVH

`ifndef SYNTH
`define LBCC_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbcc assertion failed");
`define LBCC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbcc assertion failed");
`else
`define LBCC_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define LBCC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/lbcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbcc_pkg;

  localparam int unsigned LBCC_MAX_DIM    = 256;
  localparam int unsigned LBCC_NUM_LABELS = 1024;

  localparam int unsigned LABEL_W   = 10;
  localparam int unsigned DIM_REG_W = 9;
  localparam int unsigned GRID_W    = 12;
  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [1:0] SEEN_LIMIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'b1;

endpackage

`default_nettype wire

// File: hw/rtl/lbcc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lbcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/label_bbox_coverage_counter.sv
// pixels: one transaction per cycle while busy is low, label state updated by
// read-modify-write in a label ram; after the last pixel: a flush, a read and check of each
// label up to the highest one, a grid read and write per corner of each painted box, then a
// prefix walk through the grid ram per image pixel; a change of image_cols holds busy while
// the raster row/column is re-derived; reset and every result are followed by a clearing
// pass over max((MAX_DIM+1)^2, NUM_LABELS) addresses; done_o lasts one cycle, cannot stall
`timescale 1ns / 1ps
`default_nettype none
`include "label_bbox_coverage_counter_macros.svh"

module label_bbox_coverage_counter
  import lbcc_pkg::*;
#(
  parameter int unsigned MaxDim    = LBCC_MAX_DIM,
  parameter int unsigned NumLabels = LBCC_NUM_LABELS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [LABEL_W-1:0]   pixel_label_i,
  input  wire logic                 last_pixel_i,
  output logic                      done_o,
  output logic [COUNT_W-1:0]        uncovered_pixels_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_REG_W-1:0] cfg_wdata_i
);

  localparam int unsigned DW       = $clog2(MaxDim + 1);
  localparam int unsigned CW       = $clog2(MaxDim);
  localparam int unsigned PW       = $clog2(MaxDim * MaxDim + 1);
  localparam int unsigned GridSide = MaxDim + 1;
  localparam int unsigned GDepth   = GridSide * GridSide;
  localparam int unsigned GAW      = $clog2(GDepth);
  localparam int unsigned LAW      = $clog2(NumLabels);
  localparam int unsigned EW       = 2 + 4 * CW;
  localparam int unsigned ClrLen   = (GDepth > NumLabels) ? GDepth : NumLabels;
  localparam int unsigned CLRW     = $clog2(ClrLen);
  localparam int unsigned DCW      = $clog2(PW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_FLUSH = 4'd2;
  localparam logic [3:0] S_LRD   = 4'd3;
  localparam logic [3:0] S_LCHK  = 4'd4;
  localparam logic [3:0] S_GRD   = 4'd5;
  localparam logic [3:0] S_GWR   = 4'd6;
  localparam logic [3:0] S_PA    = 4'd7;
  localparam logic [3:0] S_PB    = 4'd8;
  localparam logic [3:0] S_PC    = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;
  localparam logic [3:0] S_CLR   = 4'd11;

  localparam logic [EW-1:0] EntryReset = {2'b00, {CW{1'b1}}, {CW{1'b0}}, {CW{1'b1}}, {CW{1'b0}}};

  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    if (v == '0) begin
      return DW'(1);
    end
    if (32'(v) > MaxDim) begin
      return DW'(MaxDim);
    end
    return DW'(v);
  endfunction

  function automatic logic [GAW-1:0] gaddr(input logic [DW-1:0] r, input logic [DW-1:0] c);
    return GAW'(r) * GAW'(GridSide) + GAW'(c);
  endfunction

  // control registers
  logic [3:0]           state_q, state_d;
  logic [DIM_REG_W-1:0] image_rows_q, image_rows_d;
  logic [DIM_REG_W-1:0] image_cols_q, image_cols_d;
  logic [DW-1:0]        cols_used_q, cols_used_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic [DW-1:0]        row_q, row_d;
  logic [DW-1:0]        col_q, col_d;
  logic [LABEL_W-1:0]   highest_q, highest_d;
  logic                 s1_valid_q, s1_valid_d;
  logic                 fwd_valid_q;
  logic [DCW-1:0]       div_cnt_q, div_cnt_d;
  logic [LABEL_W:0]     scan_q, scan_d;
  logic [1:0]           corner_q, corner_d;
  logic [DW-1:0]        wr_q, wr_d;
  logic [DW-1:0]        wc_q, wc_d;
  logic [COUNT_W-1:0]   total_q, total_d;
  logic [CLRW-1:0]      clr_q, clr_d;

  // payload registers
  logic [LAW-1:0]    s1_label_q, s1_label_d;
  logic [CW-1:0]     s1_row_q, s1_row_d;
  logic [CW-1:0]     s1_col_q, s1_col_d;
  logic [LAW-1:0]    fwd_label_q;
  logic [EW-1:0]     fwd_data_q;
  logic [PW-1:0]     div_num_q, div_num_d;
  logic [DW-1:0]     div_rem_q, div_rem_d;
  logic [PW-1:0]     div_quo_q, div_quo_d;
  logic [CW-1:0]     box_minr_q, box_minr_d;
  logic [CW-1:0]     box_maxr_q, box_maxr_d;
  logic [CW-1:0]     box_minc_q, box_minc_d;
  logic [CW-1:0]     box_maxc_q, box_maxc_d;
  logic [DW-1:0]     walk_rows_q, walk_rows_d;
  logic [DW-1:0]     walk_cols_q, walk_cols_d;
  logic [GRID_W-1:0] row_acc_q, row_acc_d;
  logic [GRID_W-1:0] above_q, above_d;

  // memories
  logic              l_we;
  logic [LAW-1:0]    l_waddr, l_raddr;
  logic [EW-1:0]     l_wdata, l_rdata;
  logic              g_we;
  logic [GAW-1:0]    g_waddr, g_raddr;
  logic [GRID_W-1:0] g_wdata, g_rdata;

  lbcc_ram #(.Width(EW), .Depth(NumLabels)) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  lbcc_ram #(.Width(GRID_W), .Depth(GDepth)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  logic [DW-1:0]     rows_c, cols_c;
  logic [PW-1:0]     img_pixels;
  logic              cols_stale;
  logic              accept;
  logic              in_image;
  logic              label_ok;
  logic [EW-1:0]     old_e, new_e;
  logic [1:0]        old_cnt;
  logic [DW:0]       rem_sh;
  logic              rem_ge;
  logic [DW-1:0]     rem_nx;
  logic [PW-1:0]     quo_nx;
  logic [DW-1:0]     cr, cc;
  logic [GRID_W-1:0] acc, vsum;

  assign rows_c     = clamp_dim(image_rows_q);
  assign cols_c     = clamp_dim(image_cols_q);
  assign img_pixels = PW'(rows_c) * PW'(cols_c);
  assign cols_stale = cols_c != cols_used_q;
  assign busy       = (state_q != S_IDLE) || cols_stale;
  assign accept     = start && !busy;
  assign in_image   = pos_q < img_pixels;
  assign label_ok   = 32'(pixel_label_i) < NumLabels;

  assign done_o             = state_q == S_DONE;
  assign uncovered_pixels_o = total_q;

  // merge with the write of the previous cycle, which the ram read did not see yet
  assign old_e   = (fwd_valid_q && fwd_label_q == s1_label_q) ? fwd_data_q : l_rdata;
  assign old_cnt = old_e[EW-1 -: 2];
  always_comb begin
    new_e = old_e;
    if (old_cnt < SEEN_LIMIT) begin
      new_e[EW-1 -: 2] = old_cnt + 2'd1;
    end
    if (s1_row_q < old_e[4*CW-1 -: CW]) new_e[4*CW-1 -: CW] = s1_row_q;
    if (s1_row_q > old_e[3*CW-1 -: CW]) new_e[3*CW-1 -: CW] = s1_row_q;
    if (s1_col_q < old_e[2*CW-1 -: CW]) new_e[2*CW-1 -: CW] = s1_col_q;
    if (s1_col_q > old_e[CW-1:0])       new_e[CW-1:0]       = s1_col_q;
  end

  // one restoring division step for raster position / columns
  assign rem_sh = {div_rem_q, div_num_q[PW-1]};
  assign rem_ge = rem_sh >= {1'b0, cols_c};
  assign rem_nx = rem_ge ? DW'(rem_sh - {1'b0, cols_c}) : DW'(rem_sh);
  assign quo_nx = {div_quo_q[PW-2:0], rem_ge};

  // corner of the difference grid for the current box
  always_comb begin
    case (corner_q)
      2'd0: begin cr = DW'(box_minr_q);          cc = DW'(box_minc_q); end
      2'd1: begin cr = DW'(box_minr_q);          cc = DW'(box_maxc_q) + DW'(1); end
      2'd2: begin cr = DW'(box_maxr_q) + DW'(1); cc = DW'(box_minc_q); end
      default: begin
        cr = DW'(box_maxr_q) + DW'(1);
        cc = DW'(box_maxc_q) + DW'(1);
      end
    endcase
  end

  assign acc  = row_acc_q + g_rdata;
  assign vsum = above_q + acc;

  always_comb begin
    state_d      = state_q;
    image_rows_d = image_rows_q;
    image_cols_d = image_cols_q;
    cols_used_d  = cols_used_q;
    pos_d        = pos_q;
    row_d        = row_q;
    col_d        = col_q;
    highest_d    = highest_q;
    s1_valid_d   = 1'b0;
    div_cnt_d    = div_cnt_q;
    scan_d       = scan_q;
    corner_d     = corner_q;
    wr_d         = wr_q;
    wc_d         = wc_q;
    total_d      = total_q;
    clr_d        = clr_q;
    s1_label_d   = s1_label_q;
    s1_row_d     = s1_row_q;
    s1_col_d     = s1_col_q;
    div_num_d    = div_num_q;
    div_rem_d    = div_rem_q;
    div_quo_d    = div_quo_q;
    box_minr_d   = box_minr_q;
    box_maxr_d   = box_maxr_q;
    box_minc_d   = box_minc_q;
    box_maxc_d   = box_maxc_q;
    walk_rows_d  = walk_rows_q;
    walk_cols_d  = walk_cols_q;
    row_acc_d    = row_acc_q;
    above_d      = above_q;

    l_we    = s1_valid_q;
    l_waddr = s1_label_q;
    l_wdata = new_e;
    l_raddr = LAW'(pixel_label_i);
    g_we    = 1'b0;
    g_waddr = gaddr(wr_q, wc_q);
    g_wdata = vsum;
    g_raddr = gaddr(cr, cc);

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_ROWS: image_rows_d = cfg_wdata_i;
        REG_IMAGE_COLS: image_cols_d = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (cols_stale) begin
          state_d   = S_DIV;
          div_num_d = pos_q;
          div_rem_d = '0;
          div_quo_d = '0;
          div_cnt_d = '0;
        end else if (accept) begin
          if (in_image) begin
            pos_d = pos_q + PW'(1);
            if (col_q + DW'(1) == cols_c) begin
              col_d = '0;
              row_d = row_q + DW'(1);
            end else begin
              col_d = col_q + DW'(1);
            end
            if (label_ok) begin
              s1_valid_d = 1'b1;
              s1_label_d = LAW'(pixel_label_i);
              s1_row_d   = CW'(row_q);
              s1_col_d   = CW'(col_q);
              if (pixel_label_i > highest_q) highest_d = pixel_label_i;
            end
          end
          if (last_pixel_i) begin
            walk_rows_d = rows_c;
            walk_cols_d = cols_c;
            scan_d      = (LABEL_W + 1)'(1);
            state_d     = S_FLUSH;
          end
        end
      end
      S_DIV: begin
        div_rem_d = rem_nx;
        div_quo_d = quo_nx;
        div_num_d = {div_num_q[PW-2:0], 1'b0};
        div_cnt_d = div_cnt_q + DCW'(1);
        if (div_cnt_q == DCW'(PW - 1)) begin
          row_d       = DW'(quo_nx);
          col_d       = rem_nx;
          cols_used_d = cols_c;
          state_d     = S_IDLE;
        end
      end
      S_FLUSH: state_d = S_LRD;
      S_LRD: begin
        l_raddr = LAW'(scan_q);
        if (scan_q <= {1'b0, highest_q} && 32'(scan_q) < NumLabels) begin
          state_d = S_LCHK;
        end else begin
          wr_d      = '0;
          wc_d      = '0;
          row_acc_d = '0;
          total_d   = '0;
          state_d   = S_PA;
        end
      end
      S_LCHK: begin
        if (l_rdata[EW-1 -: 2] >= SEEN_LIMIT) begin
          box_minr_d = l_rdata[4*CW-1 -: CW];
          box_maxr_d = l_rdata[3*CW-1 -: CW];
          box_minc_d = l_rdata[2*CW-1 -: CW];
          box_maxc_d = l_rdata[CW-1:0];
          corner_d   = 2'd0;
          state_d    = S_GRD;
        end else begin
          scan_d  = scan_q + (LABEL_W + 1)'(1);
          state_d = S_LRD;
        end
      end
      S_GRD: state_d = S_GWR;
      S_GWR: begin
        g_we    = 1'b1;
        g_waddr = gaddr(cr, cc);
        g_wdata = (corner_q == 2'd0 || corner_q == 2'd3) ? g_rdata + GRID_W'(1)
                                                         : g_rdata - GRID_W'(1);
        corner_d = corner_q + 2'd1;
        if (corner_q == 2'd3) begin
          scan_d  = scan_q + (LABEL_W + 1)'(1);
          state_d = S_LRD;
        end else begin
          state_d = S_GRD;
        end
      end
      S_PA: begin
        g_raddr = gaddr(wr_q - DW'(1), wc_q);
        state_d = S_PB;
      end
      S_PB: begin
        above_d = (wr_q == '0) ? '0 : g_rdata;
        g_raddr = gaddr(wr_q, wc_q);
        state_d = S_PC;
      end
      S_PC: begin
        // row running sum of differences plus the finished value above
        g_we      = 1'b1;
        row_acc_d = acc;
        if (vsum == '0) total_d = total_q + COUNT_W'(1);
        state_d = S_PA;
        if (wc_q + DW'(1) == walk_cols_q) begin
          wc_d      = '0;
          row_acc_d = '0;
          if (wr_q + DW'(1) == walk_rows_q) begin
            state_d = S_DONE;
          end else begin
            wr_d = wr_q + DW'(1);
          end
        end else begin
          wc_d = wc_q + DW'(1);
        end
      end
      S_DONE: begin
        pos_d     = '0;
        row_d     = '0;
        col_d     = '0;
        highest_d = '0;
        clr_d     = '0;
        state_d   = S_CLR;
      end
      S_CLR: begin
        l_we    = 32'(clr_q) < NumLabels;
        l_waddr = LAW'(clr_q);
        l_wdata = EntryReset;
        g_we    = 32'(clr_q) < GDepth;
        g_waddr = GAW'(clr_q);
        g_wdata = '0;
        clr_d   = clr_q + CLRW'(1);
        if (clr_q == CLRW'(ClrLen - 1)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      image_rows_q <= DIM_REG_W'(256);
      image_cols_q <= DIM_REG_W'(256);
      cols_used_q  <= clamp_dim(DIM_REG_W'(256));
      pos_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
      highest_q    <= '0;
      s1_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
      div_cnt_q    <= '0;
      scan_q       <= '0;
      corner_q     <= '0;
      wr_q         <= '0;
      wc_q         <= '0;
      total_q      <= '0;
      clr_q        <= '0;
    end else begin
      state_q      <= state_d;
      image_rows_q <= image_rows_d;
      image_cols_q <= image_cols_d;
      cols_used_q  <= cols_used_d;
      pos_q        <= pos_d;
      row_q        <= row_d;
      col_q        <= col_d;
      highest_q    <= highest_d;
      s1_valid_q   <= s1_valid_d;
      fwd_valid_q  <= s1_valid_q;
      div_cnt_q    <= div_cnt_d;
      scan_q       <= scan_d;
      corner_q     <= corner_d;
      wr_q         <= wr_d;
      wc_q         <= wc_d;
      total_q      <= total_d;
      clr_q        <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_label_q  <= s1_label_d;
    s1_row_q    <= s1_row_d;
    s1_col_q    <= s1_col_d;
    fwd_label_q <= s1_label_q;
    fwd_data_q  <= new_e;
    div_num_q   <= div_num_d;
    div_rem_q   <= div_rem_d;
    div_quo_q   <= div_quo_d;
    box_minr_q  <= box_minr_d;
    box_maxr_q  <= box_maxr_d;
    box_minc_q  <= box_minc_d;
    box_maxc_q  <= box_maxc_d;
    walk_rows_q <= walk_rows_d;
    walk_cols_q <= walk_cols_d;
    row_acc_q   <= row_acc_d;
    above_q     <= above_d;
  end

  `LBCC_ASSERT_IMPLIES(a_done_while_busy, clk_i, rst_ni, done_o, busy)
  `LBCC_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `LBCC_ASSERT_IMPLIES(a_label_write_phase, clk_i, rst_ni, s1_valid_q, state_q == S_IDLE || state_q == S_FLUSH || state_q == S_DIV)
  `LBCC_ASSERT_NEXT(a_last_flushes, clk_i, rst_ni, accept && last_pixel_i, state_q == S_FLUSH)

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import lbcc_pkg::*;

  typedef struct {
    bit                  cfg;
    logic [DIM_REG_W-1:0] rows;
    logic [DIM_REG_W-1:0] cols;
    logic [LABEL_W-1:0]  label;
    bit                  last;
    bit                  typed;
    logic [COUNT_W-1:0]  val;
  } pix_row_t;

  localparam int GRID_SIDE = LBCC_MAX_DIM + 1;
  localparam int QUIET_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [LABEL_W-1:0] pixel_label_i = '0;
  logic last_pixel_i = 1'b0;
  logic done_o;
  logic [COUNT_W-1:0] uncovered_pixels_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_IMAGE_ROWS;
  logic [DIM_REG_W-1:0] cfg_wdata_i = '0;

  label_bbox_coverage_counter DUT (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [DIM_REG_W-1:0] dim_rows, dim_cols;
  logic [1:0] seen_cnt [LBCC_NUM_LABELS];
  int min_r [LBCC_NUM_LABELS], max_r [LBCC_NUM_LABELS];
  int min_c [LBCC_NUM_LABELS], max_c [LBCC_NUM_LABELS];
  int grid [GRID_SIDE*GRID_SIDE];
  int raster_pos, top_label;

  logic [COUNT_W-1:0] uncovered_q [$];
  pix_row_t plan [$];
  int errors = 0;
  int quiet = 0;
  bit acc_q = 1'b0;
  bit no_idle = 1'b0;

  function automatic int clamp_dim(logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > LBCC_MAX_DIM) return LBCC_MAX_DIM;
    return v;
  endfunction

  task automatic clear_labels();
    for (int k = 0; k < LBCC_NUM_LABELS; k++) begin
      seen_cnt[k] = 0; min_r[k] = 'hffff; min_c[k] = 'hffff; max_r[k] = 0; max_c[k] = 0;
    end
    raster_pos = 0;
    top_label = 0;
  endtask

  function automatic logic [COUNT_W-1:0] count_uncovered();
    int rows, cols, v, total;
    rows = clamp_dim(dim_rows);
    cols = clamp_dim(dim_cols);
    total = 0;
    foreach (grid[k]) grid[k] = 0;
    for (int lab = 1; lab <= top_label; lab++) begin
      if (seen_cnt[lab] >= SEEN_LIMIT) begin
        grid[min_r[lab]*GRID_SIDE + min_c[lab]] += 1;
        grid[min_r[lab]*GRID_SIDE + max_c[lab] + 1] -= 1;
        grid[(max_r[lab]+1)*GRID_SIDE + min_c[lab]] -= 1;
        grid[(max_r[lab]+1)*GRID_SIDE + max_c[lab] + 1] += 1;
      end
    end
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        v = grid[r*GRID_SIDE + c];
        if (r > 0) v += grid[(r-1)*GRID_SIDE + c];
        if (c > 0) v += grid[r*GRID_SIDE + c - 1];
        if (r > 0 && c > 0) v -= grid[(r-1)*GRID_SIDE + c - 1];
        grid[r*GRID_SIDE + c] = v;
        if (v == 0) total++;
      end
    end
    return total[COUNT_W-1:0];
  endfunction

  // returns 1 when the pixel closes the image
  function automatic bit place_pixel(logic [LABEL_W-1:0] label, bit last);
    int rows, cols, r, c;
    rows = clamp_dim(dim_rows);
    cols = clamp_dim(dim_cols);
    if (raster_pos < rows*cols) begin
      r = raster_pos / cols;
      c = raster_pos % cols;
      raster_pos++;
      if (label > top_label) top_label = label;
      if (seen_cnt[label] < SEEN_LIMIT) seen_cnt[label]++;
      if (r < min_r[label]) min_r[label] = r;
      if (r > max_r[label]) max_r[label] = r;
      if (c < min_c[label]) min_c[label] = c;
      if (c > max_c[label]) max_c[label] = c;
    end
    return last;
  endfunction

  task automatic add_row(bit cfg, int rows, int cols, int label, bit last,
                         bit typed = 0, int val = 0);
    pix_row_t p;
    p.cfg = cfg; p.rows = rows; p.cols = cols; p.label = label; p.last = last;
    p.typed = typed; p.val = val;
    plan.push_back(p);
  endtask

  // wait until nothing is outstanding and the clearing pass is over
  task automatic wait_idle();
    while (uncovered_q.size() != 0 || busy) @(negedge clk_i);
  endtask

  task automatic write_dims(logic [DIM_REG_W-1:0] rows, logic [DIM_REG_W-1:0] cols);
    wait_idle();
    cfg_we_i <= 1'b1; cfg_idx_i <= REG_IMAGE_ROWS; cfg_wdata_i <= rows;
    @(negedge clk_i);
    cfg_idx_i <= REG_IMAGE_COLS; cfg_wdata_i <= cols;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    dim_rows = rows;
    dim_cols = cols;
  endtask

  task automatic send_pixel(pix_row_t p);
    while (!no_idle && $urandom_range(0, 99) < 18) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    pixel_label_i <= p.label;
    last_pixel_i <= p.last;
    do @(negedge clk_i); while (!acc_q);
    if (place_pixel(p.label, p.last)) begin
      if (p.typed) uncovered_q.push_back(p.val);
      else uncovered_q.push_back(count_uncovered());
      clear_labels();
    end
    if (p.last) start <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    acc_q <= start && !busy;
    if (rst_ni && done_o) begin
      if (uncovered_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 uncovered_pixels_o);
        errors++;
      end else begin
        if (uncovered_pixels_o !== uncovered_q[0]) begin
          $display("%0t: uncovered_pixels mismatch, expected %0d, actual %0d", $time,
                   uncovered_q[0], uncovered_pixels_o);
          errors++;
        end
        void'(uncovered_q.pop_front());
      end
    end
    if ((start && !busy) || done_o) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int rows, cols, npix, lastpos;
    dim_rows = 256;
    dim_cols = 256;
    clear_labels();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // whole default grid, one pixel only
    add_row(0, 0, 0, 5, 1, 1, 65536);
    // zero dimensions act as one
    add_row(1, 0, 0, 3, 1, 1, 1);
    // one label covering everything
    add_row(1, 2, 2, 7, 0); add_row(0, 0, 0, 7, 0); add_row(0, 0, 0, 7, 0);
    add_row(0, 0, 0, 7, 1, 1, 0);
    // label zero never paints
    add_row(1, 2, 2, 0, 0); add_row(0, 0, 0, 0, 0); add_row(0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 1, 1, 4);
    // oversize rows clamp, top label
    add_row(1, 511, 3, 1, 0); add_row(0, 0, 0, 2, 0); add_row(0, 0, 0, 1, 0);
    add_row(0, 0, 0, 0, 0); add_row(0, 0, 0, 1023, 0); add_row(0, 0, 0, 1023, 1);
    // surplus pixels ignored
    add_row(1, 1, 2, 9, 0); add_row(0, 0, 0, 0, 0); add_row(0, 0, 0, 9, 0);
    add_row(0, 0, 0, 9, 1);
    // short image
    add_row(1, 3, 256, 4, 0); add_row(0, 0, 0, 5, 0); add_row(0, 0, 0, 4, 1);

    foreach (plan[i]) begin
      if (plan[i].cfg) write_dims(plan[i].rows, plan[i].cols);
      send_pixel(plan[i]);
    end

    for (int img = 0; img < 17; img++) begin
      pix_row_t p;
      rows = $urandom_range(1, 14);
      cols = $urandom_range(1, 14);
      if (img == 2) rows = 0;
      write_dims(rows, cols);
      npix = clamp_dim(rows) * clamp_dim(cols);
      case ($urandom_range(0, 3))
        0: lastpos = $urandom_range(1, npix);
        1: lastpos = npix + $urandom_range(1, 8);
        default: lastpos = npix;
      endcase
      if (lastpos > 180) lastpos = 180;
      no_idle = (img == 4);
      for (int k = 1; k <= lastpos; k++) begin
        p.cfg = 0; p.typed = 0; p.val = 0;
        p.label = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 6);
        p.last = (k == lastpos);
        send_pixel(p);
      end
    end

    wait_idle();
    repeat (100) @(negedge clk_i);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: label_bbox_coverage_counter.f
+incdir+hw/rtl
hw/rtl/lbcc_pkg.sv
hw/rtl/lbcc_ram.sv
hw/rtl/label_bbox_coverage_counter.sv
verif/tb.sv
